// ===== hw/rtl/atsc_pkg.sv =====
// Shared constants for the adaptive threshold step counter: field widths,
// register indexes and reset values. No dependencies.
package atsc_pkg;

  // Default sizes handed to the top level.
  localparam int SAMPLE_BITS_DEF = 13;
  localparam int COUNT_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int CFG_W      = 13;  // widest register
  localparam int STEP_W     = 8;   // adjust_step
  localparam int LEVEL_W    = 14;  // adaptive y/z thresholds
  localparam int TOTAL_W    = 32;  // reported step total
  localparam int CFG_IDX_W  = 3;

  // Result packing: step_seen, step_total, y_level, z_level, then zero fill.
  localparam int OUT_FIELDS_W = 1 + TOTAL_W + 2 * LEVEL_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAISE_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_MARGIN = 3'd5;

  // Reset values.
  localparam logic [CFG_W-1:0]   X_THRESHOLD_RST  = 13'd35;
  localparam logic [CFG_W-1:0]   THRESH_MIN_RST   = 13'd175;
  localparam logic [CFG_W-1:0]   THRESH_MAX_RST   = 13'd195;
  localparam logic [STEP_W-1:0]  ADJUST_STEP_RST  = 8'd2;
  localparam logic [CFG_W-1:0]   RAISE_MARGIN_RST = 13'd200;
  localparam logic [CFG_W-1:0]   LOWER_MARGIN_RST = 13'd175;
  localparam logic [LEVEL_W-1:0] LEVEL_RST        = 14'd185;

endpackage

// ===== hw/rtl/adaptive_threshold_step_counter_top.sv =====
// Adaptive threshold step counter, top level and only module.
// Depends on atsc_pkg for widths, register indexes and reset values.
//
// Takes one three-axis accelerometer sample per request and returns one
// result per sample: a step flag, the saturating step total and the current
// adaptive Y and Z thresholds. The first sample after reset only seeds the
// previous-sample registers. For later samples each axis computes the change
// of magnitude against the previous sample; X is checked against a fixed
// threshold, Y and Z against thresholds that move by adjust_step when the
// change overshoots them by more than raise_margin (clamped to
// thresh_min..thresh_max first). A step counts when X and (Y or Z) pass and
// the vibrating flag is low. Throughput is one sample per clock: all the
// work is a short compare/add path from the slave port into the state and
// the result register, so m_axis_tvalid rises in the cycle after
// acceptance. The result register accepts a new sample whenever it is
// empty or being drained in the same cycle; only output back-pressure stalls
// the input. Configuration registers are written through the cfg port, which
// is always ready; write them only while no sample is in flight.
module adaptive_threshold_step_counter_top #(
  parameter int SAMPLE_BITS = atsc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = atsc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [SB-1:0] accel_x, [2SB-1:SB] accel_y, [3SB-1:2SB] accel_z, zero fill
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // [0] vibrating
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] step_seen, [32:1] step_total, [46:33] y_level, [60:47] z_level
  output logic [atsc_pkg::OUT_W-1:0]          m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [atsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [atsc_pkg::CFG_W-1:0]          cfg_data
);
  import atsc_pkg::*;

  // compare width covers both the axis change and the 14-bit levels
  localparam int CW = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } adapt_t;

  // configuration registers
  logic [CFG_W-1:0]  x_threshold;
  logic [CFG_W-1:0]  thresh_min;
  logic [CFG_W-1:0]  thresh_max;
  logic [STEP_W-1:0] adjust_step;
  logic [CFG_W-1:0]  raise_margin;
  logic [CFG_W-1:0]  lower_margin;

  // sample state
  logic [SAMPLE_BITS-1:0] prev_x, prev_y, prev_z;
  logic                   seeded;
  logic [LEVEL_W-1:0]     y_thresh, z_thresh;
  logic [COUNT_BITS-1:0]  step_counter;

  logic [LEVEL_W-1:0]     y_thresh_next, z_thresh_next;
  logic [COUNT_BITS-1:0]  step_counter_next;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] cur_x, cur_y, cur_z;
  logic [SAMPLE_BITS-1:0] dx, dy, dz;
  adapt_t                 y_res, z_res;
  logic                   x_ok;
  logic                   step_hit;

  // magnitude of a two's complement sample; the most negative code maps to
  // 2^(SB-1), which still fits unsigned
  function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
    mag = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] change(input logic [SAMPLE_BITS-1:0] a,
                                                    input logic [SAMPLE_BITS-1:0] b);
    logic [SAMPLE_BITS-1:0] ma;
    logic [SAMPLE_BITS-1:0] mb;
    ma = mag(a);
    mb = mag(b);
    change = (ma >= mb) ? (ma - mb) : (mb - ma);
  endfunction

  // validity check and threshold adaptation for one adaptive axis
  function automatic adapt_t adapt_level(input logic [SAMPLE_BITS-1:0] d_in,
                                         input logic [LEVEL_W-1:0]     t,
                                         input logic [CFG_W-1:0]       mn,
                                         input logic [CFG_W-1:0]       mx,
                                         input logic [STEP_W-1:0]      stp,
                                         input logic [CFG_W-1:0]       raise,
                                         input logic [CFG_W-1:0]       lower);
    adapt_t             r;
    logic [CW-1:0]      d;
    logic [CW-1:0]      te;
    logic [LEVEL_W-1:0] mn_l;
    logic [LEVEL_W-1:0] mx_l;
    logic [LEVEL_W-1:0] stp_l;
    logic [LEVEL_W-1:0] tc;
    d     = CW'(d_in);
    te    = CW'(t);
    mn_l  = LEVEL_W'(mn);
    mx_l  = LEVEL_W'(mx);
    stp_l = LEVEL_W'(stp);
    // upper bound tested first, as the clamp is specified
    tc    = (t > mx_l) ? mx_l : ((t < mn_l) ? mn_l : t);
    r.valid = (d >= te);
    r.level = t;
    if (r.valid) begin
      if ((d - te) > CW'(raise)) begin
        r.level = (tc < mx_l) ? (tc + stp_l) : tc;
      end else if ((te > d) && ((te - d) > CW'(lower))) begin
        if (tc > mn_l) begin
          r.level = (tc >= stp_l) ? (tc - stp_l) : '0;
        end else begin
          r.level = tc;
        end
      end
    end
    return r;
  endfunction

  // Handshakes: take a sample whenever the result register is free or
  // draining this cycle.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign cur_x = s_axis_tdata[SAMPLE_BITS-1:0];
  assign cur_y = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign cur_z = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign dx = change(cur_x, prev_x);
  assign dy = change(cur_y, prev_y);
  assign dz = change(cur_z, prev_z);

  assign x_ok  = (CW'(dx) >= CW'(x_threshold));
  assign y_res = adapt_level(dy, y_thresh, thresh_min, thresh_max, adjust_step,
                             raise_margin, lower_margin);
  assign z_res = adapt_level(dz, z_thresh, thresh_min, thresh_max, adjust_step,
                             raise_margin, lower_margin);

  // the seeding sample leaves counter and thresholds alone
  assign step_hit = seeded && x_ok && (y_res.valid || z_res.valid) && !s_axis_tuser;

  always_comb begin
    y_thresh_next     = seeded ? y_res.level : y_thresh;
    z_thresh_next     = seeded ? z_res.level : z_thresh;
    step_counter_next = step_counter;
    if (step_hit && !(&step_counter)) begin
      step_counter_next = step_counter + COUNT_BITS'(1);
    end
  end

  // Configuration registers: ignore indexes beyond the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_threshold  <= X_THRESHOLD_RST;
      thresh_min   <= THRESH_MIN_RST;
      thresh_max   <= THRESH_MAX_RST;
      adjust_step  <= ADJUST_STEP_RST;
      raise_margin <= RAISE_MARGIN_RST;
      lower_margin <= LOWER_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_THRESHOLD:  x_threshold  <= cfg_data;
        REG_THRESH_MIN:   thresh_min   <= cfg_data;
        REG_THRESH_MAX:   thresh_max   <= cfg_data;
        REG_ADJUST_STEP:  adjust_step  <= cfg_data[STEP_W-1:0];
        REG_RAISE_MARGIN: raise_margin <= cfg_data;
        REG_LOWER_MARGIN: lower_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample state: advance on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      seeded       <= 1'b0;
      y_thresh     <= LEVEL_RST;
      z_thresh     <= LEVEL_RST;
      step_counter <= '0;
    end else if (accept) begin
      prev_x       <= cur_x;
      prev_y       <= cur_y;
      prev_z       <= cur_z;
      seeded       <= 1'b1;
      y_thresh     <= y_thresh_next;
      z_thresh     <= z_thresh_next;
      step_counter <= step_counter_next;
    end
  end

  // Result register: load on accept, drop valid once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= OUT_W'({z_thresh_next, y_thresh_next,
                              TOTAL_W'(step_counter_next), step_hit});
    end
  end

  // The counter only moves up, and only by one.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (step_counter == $past(step_counter)) ||
                    (step_counter == $past(step_counter) + COUNT_BITS'(1)))
    else $error("step counter jumped or fell");

  // A counted step raises the counter unless it is already full.
  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    accept && step_hit |=> (step_counter == $past(step_counter) + COUNT_BITS'(1)) ||
                           (&step_counter))
    else $error("step seen but counter did not advance");

  // The seeding sample never counts a step.
  a_seed_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && !seeded |-> !step_hit)
    else $error("step counted on the seeding sample");

endmodule

// ===== dv/tb_adaptive_threshold_step_counter_top.sv =====
// Self-checking testbench for adaptive_threshold_step_counter_top: drives samples,
// configuration writes and random back-pressure, and predicts every result.
// Depends on atsc_pkg and the RTL top level only.
module tb_adaptive_threshold_step_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import atsc_pkg::*;

  localparam int SB             = SAMPLE_BITS_DEF;
  localparam int IN_W           = ((3 * SB + 7) / 8) * 8;
  localparam int CLK_HALF       = 1;
  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 10;

  // Indexes beyond the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One sample request as it sits in s_axis_tdata, accel_x in the low bits.
  typedef struct packed {
    logic signed [SB-1:0] accel_z;
    logic signed [SB-1:0] accel_y;
    logic signed [SB-1:0] accel_x;
  } sample_t;

  // One result as it sits in m_axis_tdata, step_seen in bit 0.
  typedef struct packed {
    logic [LEVEL_W-1:0] z_level;
    logic [LEVEL_W-1:0] y_level;
    logic [TOTAL_W-1:0] step_total;
    logic               step_seen;
  } step_result_t;

  // Step predictor: own copy of the registers and the counter state, and the
  // queue of results that accepted samples still owe.
  class step_tracker;
    int x_thr, lvl_min, lvl_max, nudge, raise_mg, lower_mg;
    logic signed [SB-1:0] last_x, last_y, last_z;
    bit primed;
    int y_lvl, z_lvl;
    logic [TOTAL_W-1:0] steps;
    step_result_t owed_q[$];
    int fail_count;

    function new();
      x_thr    = int'(X_THRESHOLD_RST);
      lvl_min  = int'(THRESH_MIN_RST);
      lvl_max  = int'(THRESH_MAX_RST);
      nudge    = int'(ADJUST_STEP_RST);
      raise_mg = int'(RAISE_MARGIN_RST);
      lower_mg = int'(LOWER_MARGIN_RST);
      last_x = '0;
      last_y = '0;
      last_z = '0;
      primed = 1'b0;
      y_lvl  = int'(LEVEL_RST);
      z_lvl  = int'(LEVEL_RST);
      steps  = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_X_THRESHOLD:  x_thr    = int'(data);
        REG_THRESH_MIN:   lvl_min  = int'(data);
        REG_THRESH_MAX:   lvl_max  = int'(data);
        REG_ADJUST_STEP:  nudge    = int'(data[STEP_W-1:0]);
        REG_RAISE_MARGIN: raise_mg = int'(data);
        REG_LOWER_MARGIN: lower_mg = int'(data);
        default: ;
      endcase
    endfunction

    function int magnitude(logic signed [SB-1:0] v);
      return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function int axis_delta(logic signed [SB-1:0] cur, logic signed [SB-1:0] prev);
      int diff;
      diff = magnitude(cur) - magnitude(prev);
      return (diff < 0) ? -diff : diff;
    endfunction

    // Upper bound first: with inverted bounds, t > lvl_max gives lvl_max, else lvl_min.
    function int clamp_level(int t);
      if (t > lvl_max) return lvl_max;
      if (t < lvl_min) return lvl_min;
      return t;
    endfunction

    function bit adapt_level(int d, ref int t);
      if (d < t) return 1'b0;
      if (d - t > raise_mg) begin
        t = clamp_level(t);
        if (t < lvl_max) t = t + nudge;
      end else if (t - d > lower_mg) begin
        t = clamp_level(t);
        if (t > lvl_min) begin
          t = t - nudge;
          if (t < 0) t = 0;
        end
      end
      return 1'b1;
    endfunction

    function void note_sample(sample_t s, bit shaking);
      step_result_t r;
      bit hit_x, hit_y, hit_z, counted;
      counted = 1'b0;
      if (primed) begin
        hit_x = axis_delta(s.accel_x, last_x) >= x_thr;
        hit_y = adapt_level(axis_delta(s.accel_y, last_y), y_lvl);
        hit_z = adapt_level(axis_delta(s.accel_z, last_z), z_lvl);
        if (hit_x && (hit_y || hit_z) && !shaking) begin
          counted = 1'b1;
          if (steps != '1) steps = steps + 1'b1;
        end
      end else begin
        primed = 1'b1;
      end
      last_x = s.accel_x;
      last_y = s.accel_y;
      last_z = s.accel_z;
      r.step_seen  = counted;
      r.step_total = steps;
      r.y_level    = y_lvl[LEVEL_W-1:0];
      r.z_level    = z_lvl[LEVEL_W-1:0];
      owed_q.push_back(r);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: step_seen %0d step_total %0d", got.step_seen,
               got.step_total);
        fail_count++;
        return;
      end
      want = owed_q.pop_front();
      if (got.step_seen !== want.step_seen) begin
        $error("step_seen: expected %0d, got %0d", want.step_seen, got.step_seen);
        fail_count++;
      end
      if (got.step_total !== want.step_total) begin
        $error("step_total: expected %0d, got %0d", want.step_total, got.step_total);
        fail_count++;
      end
      if (got.y_level !== want.y_level) begin
        $error("y_level: expected %0d, got %0d", want.y_level, got.y_level);
        fail_count++;
      end
      if (got.z_level !== want.z_level) begin
        $error("z_level: expected %0d, got %0d", want.z_level, got.z_level);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;   // [12:0] accel_x, [25:13] accel_y, [38:26] accel_z
  logic s_axis_tuser;              // [0] vibrating
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;  // [0] step_seen, [32:1] step_total, [46:33] y, [60:47] z
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Idling controls shared between the stimulus and the receiver.
  bit tx_gaps_on  = 1'b1;
  bit rx_stall_on = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;

  step_tracker sb = new();

  adaptive_threshold_step_counter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Observe every channel at the rising edge: inputs only move on the falling
  // edge, so the values seen here are the ones the block registers.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(sample_t'(s_axis_tdata[3*SB-1:0]), s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(step_result_t'(m_axis_tdata[OUT_FIELDS_W-1:0]));
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here once the
  // stimulus raises hold_req.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_stall_on || ($urandom_range(99) >= 32);
    end
  end

  // End the run once nothing has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_adaptive_threshold_step_counter_top failed");
    $finish;
  end

  // Offer one sample request; called and returning at a falling edge. Leave
  // tvalid high so back-to-back requests never lower and raise it in one step.
  task automatic send_sample(input logic signed [SB-1:0] ax, input logic signed [SB-1:0] ay,
                             input logic signed [SB-1:0] az, input bit shaking);
    sample_t pkt;
    while (tx_gaps_on && ($urandom_range(99) < 32)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    pkt.accel_x = ax;
    pkt.accel_y = ay;
    pkt.accel_z = az;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(pkt);
    s_axis_tuser  <= shaking;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every owed result has been drained.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int xt, input int mn, input int mx, input int st,
                               input int rm, input int lm);
    put_reg(REG_X_THRESHOLD, xt);
    put_reg(REG_THRESH_MIN, mn);
    put_reg(REG_THRESH_MAX, mx);
    put_reg(REG_ADJUST_STEP, st);
    put_reg(REG_RAISE_MARGIN, rm);
    put_reg(REG_LOWER_MARGIN, lm);
    cfg_valid <= 1'b0;
  endtask

  // Mostly swings of a few hundred milli-g so that the adaptive levels get
  // crossed and nudged; the rest full range, near-still and the rail values.
  function automatic logic signed [SB-1:0] rand_axis();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 45) v = int'($urandom_range(1800)) - 900;
    else if (pick < 65) v = int'($urandom_range(8191)) - 4096;
    else if (pick < 85) v = int'($urandom_range(120)) - 60;
    else begin
      case ($urandom_range(3))
        0: v = -4096;
        1: v = 4095;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[SB-1:0];
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_sample(rand_axis(), rand_axis(), rand_axis(), $urandom_range(99) < 15);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_X_THRESHOLD;
    cfg_data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples on the reset settings. The first one only seeds.
    send_sample(0, 0, 0, 0);
    send_sample(35, 185, 0, 0);          // x just on its threshold, y exactly on its level
    send_sample(0, 1, 0, 0);             // y one short of its level
    send_sample(34, 386, 386, 0);        // x one short; y at the raise margin, z one past it
    send_sample(-4096, -4095, 4095, 1);  // big swing while vibrating
    send_sample(4095, 0, 0, 0);          // x magnitude barely moves
    send_sample(-4096, 4095, -4096, 0);
    send_sample(0, 0, 0, 0);             // full-scale drop on every axis
    send_sample(-1, -1, -1, 0);
    send_sample(1, 1, 1, 0);             // sign flip with no change of magnitude
    send_sample(2048, -2048, 2048, 0);
    send_sample(-2048, 2048, -2048, 0);
    send_sample(4095, 4095, 4095, 1);
    send_sample(-4096, -4096, -4096, 0);
    send_sample(0, 0, 4095, 0);          // x and y swing, z barely moves
    send_sample(100, 300, 0, 0);
    send_sample(-300, -500, 200, 0);
    send_sample(1000, 1000, 1000, 0);
    send_sample(-1, 2, -3, 1);
    send_sample(4095, -4096, 0, 0);
    send_sample(0, 4095, -4096, 0);

    // Reset settings, with one pause of the sender until everything is back.
    send_random(175);
    drain_results();
    send_random(175);

    // Long receiver hold-off while the sender keeps offering without gaps.
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    send_random(40);
    tx_gaps_on = 1'b1;

    // No adaptation, x always passes, widest clamp window.
    drain_results();
    apply_setting(0, 0, 8191, 255, 8191, 8191);
    send_random(300);

    // Busy adaptation in a narrow window, with neither side idling.
    drain_results();
    apply_setting(200, 100, 600, 37, 50, 0);
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    send_random(350);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;

    // Inverted clamp bounds; spare indexes first, which must be ignored.
    drain_results();
    put_reg(REG_SPARE_LO, 8191);
    put_reg(REG_SPARE_HI, 0);
    apply_setting(35, 300, 100, 5, 0, 175);
    send_random(300);

    // Back to the reset values.
    drain_results();
    apply_setting(int'(X_THRESHOLD_RST), int'(THRESH_MIN_RST), int'(THRESH_MAX_RST),
                  int'(ADJUST_STEP_RST), int'(RAISE_MARGIN_RST), int'(LOWER_MARGIN_RST));
    send_random(350);

    // Registers at their far ends: x can never pass, bounds fully inverted.
    drain_results();
    apply_setting(8191, 8191, 0, 0, 0, 0);
    send_random(250);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("tb_adaptive_threshold_step_counter_top passed");
    else
      $display("tb_adaptive_threshold_step_counter_top failed");
    $finish;
  end

endmodule
